FILE: src/iocrob_pkg.sv
package iocrob_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int SLOT_IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  localparam logic [SLOT_IDX_W:0] DEPTH_EXT = (SLOT_IDX_W+1)'(WINDOW_DEPTH);
  localparam slot_idx_t           LAST_IDX  = SLOT_IDX_W'(WINDOW_DEPTH - 1);

  // Function codes
  localparam logic [2:0] FUNC_GET    = 3'd0;
  localparam logic [2:0] FUNC_PUT    = 3'd1;
  localparam logic [2:0] FUNC_CANCEL = 3'd2;
  localparam logic [2:0] FUNC_STOP   = 3'd3;
  localparam logic [2:0] FUNC_START  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOT_RUN = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_OUT_WIN = 2'd3;

  typedef enum logic [1:0] {
    SLOT_EMPTY,
    SLOT_RESERVED,
    SLOT_FILLED
  } slot_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] ts;
    logic        reserve;
    logic [31:0] entry_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] issued_ts;
    logic        emit_valid;
    logic        emit_cancel;
    logic [63:0] emit_ts;
    logic [31:0] emit_handle;
    logic        last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic apply;
    logic walk;
    logic tail;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_end;
  } stat_t;

endpackage

FILE: src/iocrob_ram.sv
module iocrob_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/iocrob_ctrl.sv
module iocrob_ctrl
  import iocrob_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APPLY,
    S_WALK,
    S_TAIL
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_DECODE;
      S_DECODE: state_d = S_APPLY;
      S_APPLY:  state_d = stat_i.need_walk ? S_WALK : S_TAIL;
      S_WALK:   if (stat_i.walk_end) state_d = S_TAIL;
      S_TAIL:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    busy_d = (state_d != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.latch  = (state_q == S_IDLE) && start;
    cmd_o.decode = (state_q == S_DECODE);
    cmd_o.apply  = (state_q == S_APPLY);
    cmd_o.walk   = (state_q == S_WALK);
    cmd_o.tail   = (state_q == S_TAIL);
  end

  assign busy = busy_q;

endmodule

FILE: src/iocrob_dp.sv
module iocrob_dp
  import iocrob_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  req_t  req_i,
  output stat_t stat_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  // Architectural state
  logic [63:0] next_q, next_d;
  logic [63:0] oldest_q, oldest_d;
  logic        running_q, running_d;
  slot_idx_t   head_q, head_d;
  slot_e       slot_q [WINDOW_DEPTH];
  slot_e       slot_d [WINDOW_DEPTH];

  // Command and walk state
  req_t        req_q, req_d;
  logic        off_in_q, off_in_d;
  slot_idx_t   off_idx_q, off_idx_d;
  logic [1:0]  status_q, status_d;
  logic [63:0] issued_q, issued_d;
  slot_idx_t   walk_i_q, walk_i_d;
  slot_idx_t   walk_s_q, walk_s_d;
  logic [63:0] walk_ts_q, walk_ts_d;
  logic        stop_mode_q, stop_mode_d;
  logic        pend_valid_q, pend_valid_d;
  logic [63:0] pend_ts_q, pend_ts_d;
  logic        pend_cancel_q, pend_cancel_d;
  logic        pend_filled_q, pend_filled_d;
  res_t        res_q, res_d;
  logic        res_valid_q, res_valid_d;

  // Handle store
  logic        ram_we, ram_re;
  slot_idx_t   ram_waddr;
  logic [31:0] ram_rdata;

  iocrob_ram #(
    .Width (32),
    .Depth (WINDOW_DEPTH)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_q.entry_handle),
    .re_i    (ram_re),
    .raddr_i (walk_s_q),
    .rdata_o (ram_rdata)
  );

  logic              win_empty;
  logic              is_get;
  logic              moves;
  logic [63:0]       operand;
  logic [63:0]       off;
  logic [SLOT_IDX_W:0] slot_sum;
  slot_idx_t         apply_slot;
  slot_e             walk_st;
  logic              walk_stop_hit;
  logic              walk_found;
  res_t              pend_res;

  always_comb begin
    win_empty = 1'b1;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (slot_q[k] != SLOT_EMPTY) win_empty = 1'b0;
    end
  end

  assign is_get   = (req_q.func == FUNC_GET);
  assign moves    = win_empty && ((is_get && req_q.reserve) ||
                                  (req_q.func == FUNC_PUT && running_q));
  assign operand  = is_get ? next_q : req_q.ts;
  assign off      = operand - oldest_q;

  assign slot_sum   = {1'b0, head_q} + {1'b0, off_idx_q};
  assign apply_slot = (slot_sum >= DEPTH_EXT) ? SLOT_IDX_W'(slot_sum - DEPTH_EXT)
                                              : SLOT_IDX_W'(slot_sum);

  assign walk_st       = slot_q[walk_s_q];
  assign walk_stop_hit = !stop_mode_q && (walk_st == SLOT_RESERVED);
  assign walk_found    = !walk_stop_hit && (walk_st != SLOT_EMPTY);

  always_comb begin
    pend_res             = '0;
    pend_res.emit_valid  = 1'b1;
    pend_res.emit_cancel = pend_cancel_q;
    pend_res.emit_ts     = pend_ts_q;
    pend_res.emit_handle = pend_filled_q ? ram_rdata : 32'd0;
  end

  always_comb begin
    next_d        = next_q;
    oldest_d      = oldest_q;
    running_d     = running_q;
    head_d        = head_q;
    slot_d        = slot_q;
    req_d         = req_q;
    off_in_d      = off_in_q;
    off_idx_d     = off_idx_q;
    status_d      = status_q;
    issued_d      = issued_q;
    walk_i_d      = walk_i_q;
    walk_s_d      = walk_s_q;
    walk_ts_d     = walk_ts_q;
    stop_mode_d   = stop_mode_q;
    pend_valid_d  = pend_valid_q;
    pend_ts_d     = pend_ts_q;
    pend_cancel_d = pend_cancel_q;
    pend_filled_d = pend_filled_q;
    res_d         = res_q;
    res_valid_d   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = apply_slot;
    ram_re        = 1'b0;
    stat_o        = '0;

    if (cmd_i.latch) begin
      req_d = req_i;
    end

    if (cmd_i.decode) begin
      pend_valid_d = 1'b0;
      // An empty window restarts at the stamp in hand for a reserving get or a running put
      if (moves) begin
        oldest_d  = operand;
        off_in_d  = 1'b1;
        off_idx_d = '0;
      end else begin
        off_in_d  = (off[63:SLOT_IDX_W] == '0) &&
                    ({1'b0, off[SLOT_IDX_W-1:0]} < DEPTH_EXT);
        off_idx_d = off[SLOT_IDX_W-1:0];
      end
    end

    if (cmd_i.apply) begin
      status_d    = STAT_OK;
      issued_d    = '0;
      stop_mode_d = (req_q.func == FUNC_STOP);
      walk_i_d    = '0;
      walk_s_d    = head_q;
      walk_ts_d   = oldest_q;
      case (req_q.func)
        FUNC_GET: begin
          if (req_q.reserve && !off_in_q) begin
            status_d = STAT_FULL;
          end else begin
            if (req_q.reserve) slot_d[apply_slot] = SLOT_RESERVED;
            issued_d = next_q;
            next_d   = next_q + 64'd1;
          end
        end
        FUNC_PUT: begin
          if (!running_q) begin
            status_d = STAT_NOT_RUN;
          end else if (!off_in_q) begin
            status_d = STAT_OUT_WIN;
          end else begin
            slot_d[apply_slot] = SLOT_FILLED;
            ram_we             = 1'b1;
            stat_o.need_walk   = 1'b1;
          end
        end
        FUNC_CANCEL: begin
          if (!running_q) begin
            status_d = STAT_NOT_RUN;
          end else if (off_in_q && slot_q[apply_slot] != SLOT_EMPTY) begin
            slot_d[apply_slot] = SLOT_EMPTY;
            stat_o.need_walk   = 1'b1;
          end
        end
        FUNC_STOP: begin
          if (running_q) begin
            running_d        = 1'b0;
            stat_o.need_walk = 1'b1;
          end
        end
        FUNC_START: running_d = 1'b1;
        default: ;
      endcase
    end

    if (cmd_i.walk) begin
      stat_o.walk_end = walk_stop_hit || (walk_i_q == LAST_IDX);
      if (walk_stop_hit) begin
        // Hold release at the first reserved slot unless stopping
        oldest_d = walk_ts_q;
        head_d   = walk_s_q;
      end else if (walk_found) begin
        ram_re            = 1'b1;
        slot_d[walk_s_q]  = SLOT_EMPTY;
        // Send the previous beat now that a later one exists
        if (pend_valid_q) begin
          res_d       = pend_res;
          res_valid_d = 1'b1;
        end
        pend_valid_d  = 1'b1;
        pend_ts_d     = walk_ts_q;
        pend_cancel_d = stop_mode_q;
        pend_filled_d = (walk_st == SLOT_FILLED);
      end
      walk_i_d  = walk_i_q + SLOT_IDX_W'(1);
      walk_s_d  = (walk_s_q == LAST_IDX) ? '0 : walk_s_q + SLOT_IDX_W'(1);
      walk_ts_d = walk_ts_q + 64'd1;
    end

    if (cmd_i.tail) begin
      res_valid_d = 1'b1;
      if (pend_valid_q) begin
        res_d = pend_res;
      end else begin
        res_d           = '0;
        res_d.status    = status_q;
        res_d.issued_ts = issued_q;
      end
      res_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q       <= '0;
      oldest_q     <= '0;
      running_q    <= 1'b0;
      head_q       <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        slot_q[k] <= SLOT_EMPTY;
      end
    end else begin
      next_q       <= next_d;
      oldest_q     <= oldest_d;
      running_q    <= running_d;
      head_q       <= head_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
      slot_q       <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    off_in_q      <= off_in_d;
    off_idx_q     <= off_idx_d;
    status_q      <= status_d;
    issued_q      <= issued_d;
    walk_i_q      <= walk_i_d;
    walk_s_q      <= walk_s_d;
    walk_ts_q     <= walk_ts_d;
    stop_mode_q   <= stop_mode_d;
    pend_ts_q     <= pend_ts_d;
    pend_cancel_q <= pend_cancel_d;
    pend_filled_q <= pend_filled_d;
    res_q         <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/in_order_commit_reorder_buffer.sv
// Channel   Signals                 Transfer
// command   start, busy, req_i      beat taken when start is high and busy is low
// result    res_valid_o, res_o      one beat per cycle that res_valid_o is high
//
// A command is latched on acceptance, then passes the decode, apply and tail
// states, its last result beat registered in tail, when nothing is released.
// Put, cancel and stop walk the window one slot per cycle between apply and
// tail, up to WINDOW_DEPTH slots, paced by the single read port of the handle RAM.
// Reset clears the stamps, the running flag and every slot; handles are
// written before they are read. Results cannot be held off by the receiver.
module in_order_commit_reorder_buffer
  import iocrob_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t  cmd;
  stat_t stat;

  iocrob_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  iocrob_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iocrob_pkg::*;

  localparam int DEPTH        = WINDOW_DEPTH;
  localparam int RANDOM_ITEMS = 330;
  localparam int CALM_ITEMS   = 50;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 8;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  in_order_commit_reorder_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  typedef struct {
    req_t        cmd;
    int unsigned times;
    bit          known;
    res_t        want;
  } plan_row_t;

  // Predicted window state
  logic [63:0] stamp_next;
  logic [63:0] stamp_oldest;
  bit          run_flag;
  slot_e       slot_state [DEPTH];
  logic [31:0] slot_hdl [DEPTH];
  int unsigned head;

  res_t        expected_beats [$];
  plan_row_t   plan [$];
  int          error_count = 0;
  int          cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned slot_of(int unsigned off);
    return (head + off) % DEPTH;
  endfunction

  function automatic bit window_is_empty();
    foreach (slot_state[i]) begin
      if (slot_state[i] != SLOT_EMPTY) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void post_beat(logic [1:0] st, logic [63:0] iss, logic vld, logic cnl,
                                    logic [63:0] ets, logic [31:0] hdl);
    res_t b;
    b = '0;
    b.status      = st;
    b.issued_ts   = iss;
    b.emit_valid  = vld;
    b.emit_cancel = cnl;
    b.emit_ts     = ets;
    b.emit_handle = hdl;
    expected_beats.push_back(b);
  endfunction

  // Release filled entries from the head; stop at the first reserved slot.
  function automatic void retire_ready();
    int unsigned s;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      s = slot_of(i);
      if (slot_state[s] == SLOT_RESERVED) begin
        stamp_oldest += i;
        head = s;
        return;
      end
      if (slot_state[s] == SLOT_FILLED) begin
        post_beat(STAT_OK, '0, 1'b1, 1'b0, stamp_oldest + i, slot_hdl[s]);
        slot_state[s] = SLOT_EMPTY;
      end
    end
  endfunction

  function automatic void apply_command(req_t c);
    int unsigned first_n;
    int unsigned s;
    logic [1:0]  st;
    logic [63:0] iss;
    logic [63:0] off;
    res_t        b;
    first_n = expected_beats.size();
    st  = STAT_OK;
    iss = '0;
    case (c.func)
      FUNC_GET: begin
        if (c.reserve) begin
          if (window_is_empty()) stamp_oldest = stamp_next;
          off = stamp_next - stamp_oldest;
          if (off >= DEPTH) begin
            st = STAT_FULL;
          end else begin
            slot_state[slot_of(32'(off))] = SLOT_RESERVED;
            iss = stamp_next;
            stamp_next++;
          end
        end else begin
          iss = stamp_next;
          stamp_next++;
        end
      end
      FUNC_PUT: begin
        if (!run_flag) begin
          st = STAT_NOT_RUN;
        end else begin
          if (window_is_empty()) stamp_oldest = c.ts;
          off = c.ts - stamp_oldest;
          if (off >= DEPTH) begin
            st = STAT_OUT_WIN;
          end else begin
            s = slot_of(32'(off));
            slot_state[s] = SLOT_FILLED;
            slot_hdl[s]   = c.entry_handle;
            retire_ready();
          end
        end
      end
      FUNC_CANCEL: begin
        if (!run_flag) begin
          st = STAT_NOT_RUN;
        end else begin
          off = c.ts - stamp_oldest;
          if (off < DEPTH) begin
            s = slot_of(32'(off));
            if (slot_state[s] != SLOT_EMPTY) begin
              slot_state[s] = SLOT_EMPTY;
              retire_ready();
            end
          end
        end
      end
      FUNC_STOP: begin
        if (run_flag) begin
          run_flag = 1'b0;
          for (int unsigned i = 0; i < DEPTH; i++) begin
            s = slot_of(i);
            if (slot_state[s] != SLOT_EMPTY) begin
              post_beat(STAT_OK, '0, 1'b1, 1'b1, stamp_oldest + i,
                        (slot_state[s] == SLOT_FILLED) ? slot_hdl[s] : 32'd0);
              slot_state[s] = SLOT_EMPTY;
            end
          end
        end
      end
      FUNC_START: run_flag = 1'b1;
      default: ;
    endcase
    if (expected_beats.size() == first_n) post_beat(st, iss, 1'b0, 1'b0, '0, '0);
    b = expected_beats.pop_back();
    b.last = 1'b1;
    expected_beats.push_back(b);
  endfunction

  function automatic res_t plain_beat(logic [1:0] st, logic [63:0] iss);
    res_t b;
    b = '0;
    b.status    = st;
    b.issued_ts = iss;
    b.last      = 1'b1;
    return b;
  endfunction

  function automatic void add_row(logic [2:0] func, logic [63:0] ts, logic rsv,
                                  logic [31:0] hdl, int unsigned times, bit known, res_t want);
    plan_row_t r;
    r.cmd.func         = func;
    r.cmd.ts           = ts;
    r.cmd.reserve      = rsv;
    r.cmd.entry_handle = hdl;
    r.times            = times;
    r.known            = known;
    r.want             = want;
    plan.push_back(r);
  endfunction

  // Mostly well-formed traffic around the live window, with some noise.
  function automatic req_t pick_command();
    req_t        c;
    int unsigned roll;
    logic [63:0] span;
    c.func         = FUNC_GET;
    c.ts           = {$urandom, $urandom};
    c.reserve      = 1'($urandom_range(0, 1));
    c.entry_handle = $urandom;
    span = stamp_next - stamp_oldest;
    roll = $urandom_range(0, 99);
    if (!run_flag && roll < 60) begin
      c.func = FUNC_START;
    end else if (roll < 32) begin
      c.func    = FUNC_GET;
      c.reserve = (roll < 27);
    end else if (roll < 66) begin
      c.func = FUNC_PUT;
      if (span != 0 && span <= DEPTH)
        c.ts = stamp_oldest + $urandom_range(0, 32'(span) - 1);
    end else if (roll < 76) begin
      c.func = FUNC_CANCEL;
      if (span != 0 && span <= DEPTH && roll < 73)
        c.ts = stamp_oldest + $urandom_range(0, 32'(span) - 1);
    end else if (roll < 80) begin
      c.func = FUNC_STOP;
    end else if (roll < 83) begin
      c.func = FUNC_START;
    end else if (roll < 91) begin
      c.func = FUNC_PUT;
      c.ts   = stamp_oldest + $urandom_range(0, DEPTH + 3);
    end else begin
      c.func = 3'($urandom_range(0, 7));
    end
    return c;
  endfunction

  task automatic issue(req_t c, bit known, res_t want);
    start <= 1'b1;
    req_i <= c;
    do @(posedge clk_i); while (busy);
    apply_command(c);
    if (known) begin
      void'(expected_beats.pop_back());
      expected_beats.push_back(want);
    end
  endtask

  task automatic take_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (res_valid_o === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, res_o);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status", want.status, res_o.status);
        check_field("issued_ts", want.issued_ts, res_o.issued_ts);
        check_field("emit_valid", want.emit_valid, res_o.emit_valid);
        check_field("emit_cancel", want.emit_cancel, res_o.emit_cancel);
        check_field("emit_ts", want.emit_ts, res_o.emit_ts);
        check_field("emit_handle", want.emit_handle, res_o.emit_handle);
        check_field("last", want.last, res_o.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("in_order_commit_reorder_buffer regression: fail");
      $finish;
    end
  end

  initial begin
    req_t c;
    int   useful;
    bit   paused;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    stamp_next   = '0;
    stamp_oldest = '0;
    run_flag     = 1'b0;
    head         = 0;
    foreach (slot_state[i]) begin
      slot_state[i] = SLOT_EMPTY;
      slot_hdl[i]   = '0;
    end

    // Stopped block, spare codes and field extremes
    add_row(FUNC_GET, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_PUT, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_NOT_RUN, 64'd0));
    add_row(FUNC_CANCEL, '1, 1'b0, '1, 1, 1'b1, plain_beat(STAT_NOT_RUN, 64'd0));
    add_row(FUNC_STOP, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_SPARE_LO, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_SPARE_HI, '1, 1'b1, '1, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_GET, '0, 1'b1, '0, 1, 1'b0, '0);
    add_row(FUNC_START, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_START, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    // Hole at the head, then overwrite a filled slot with a reservation
    add_row(FUNC_GET, '0, 1'b1, '0, 1, 1'b0, '0);
    add_row(FUNC_PUT, 64'd7, 1'b0, '1, 1, 1'b0, '0);
    add_row(FUNC_GET, '0, 1'b0, '0, 4, 1'b0, '0);
    add_row(FUNC_GET, '0, 1'b1, '0, 1, 1'b0, '0);
    add_row(FUNC_PUT, 64'd1, 1'b0, '0, 1, 1'b0, '0);
    add_row(FUNC_CANCEL, 64'd2, 1'b0, '0, 1, 1'b0, '0);
    add_row(FUNC_PUT, 64'd39, 1'b0, 32'h1234_5678, 1, 1'b1, plain_beat(STAT_OUT_WIN, 64'd0));
    add_row(FUNC_PUT, 64'd6, 1'b0, 32'h1234_5678, 1, 1'b1, plain_beat(STAT_OUT_WIN, 64'd0));
    add_row(FUNC_CANCEL, 64'd100, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_CANCEL, 64'd7, 1'b0, '0, 1, 1'b0, '0);
    // Empty window jumps to the put stamp and releases at once
    add_row(FUNC_PUT, '1, 1'b0, 32'd5, 1, 1'b0, '0);
    // Fill the window, overflow once, then stop with every slot busy
    add_row(FUNC_GET, '0, 1'b1, '0, DEPTH + 1, 1'b0, '0);
    add_row(FUNC_PUT, 64'd10, 1'b0, 32'hA5A5_A5A5, 1, 1'b0, '0);
    add_row(FUNC_STOP, '0, 1'b0, '0, 1, 1'b0, '0);
    add_row(FUNC_STOP, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));
    add_row(FUNC_START, '0, 1'b0, '0, 1, 1'b1, plain_beat(STAT_OK, 64'd0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      repeat (plan[k].times) begin
        issue(plan[k].cmd, plan[k].known, plan[k].want);
        take_gap();
      end
    end

    useful = 0;
    paused = 1'b0;
    while (useful < RANDOM_ITEMS) begin
      c = pick_command();
      issue(c, 1'b0, '0);
      if (c.func <= FUNC_START) useful++;
      if (!paused && useful >= RANDOM_ITEMS / 2) begin
        // Hold off until the block has delivered everything
        paused = 1'b1;
        start <= 1'b0;
        do @(posedge clk_i); while (expected_beats.size() != 0);
      end else if (useful < RANDOM_ITEMS - CALM_ITEMS) begin
        take_gap();
      end
    end
    start <= 1'b0;

    do @(posedge clk_i); while (expected_beats.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("in_order_commit_reorder_buffer regression: pass");
    else
      $display("in_order_commit_reorder_buffer regression: fail");
    $finish;
  end

endmodule
